>>> design/sc2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc2a_pkg: shared types, constants and tables for the scancode decoder
// Holds the set-1 scancode values of the modifier keys, the modifier flag
// bundle and the three character tables (lower, upper and ctrl).
// ----------------------------------------------------------------------------
package sc2a_pkg;

    localparam int CodeW = 8;
    localparam int CharW = 7;

    // Modifier scancodes, set 1
    localparam logic [CodeW-1:0] CodeShiftLMake  = 8'h2A;
    localparam logic [CodeW-1:0] CodeShiftRMake  = 8'h36;
    localparam logic [CodeW-1:0] CodeShiftLBreak = 8'hAA;
    localparam logic [CodeW-1:0] CodeShiftRBreak = 8'hB6;
    localparam logic [CodeW-1:0] CodeCtrlMake    = 8'h1D;
    localparam logic [CodeW-1:0] CodeCtrlBreak   = 8'h9D;
    localparam logic [CodeW-1:0] CodeCapsMake    = 8'h3A;

    localparam logic [CodeW-1:0] EofReset = 8'h04;

    // Modifier state passed from the flag register to the lookup logic
    typedef struct packed {
        logic shift_held;
        logic ctrl_held;
        logic caps_lock_on;
    } t_mod_flags;

    // Lower-case table; codes without a character give zero.
    function automatic logic [CharW-1:0] f_tab_lower(input logic [CodeW-1:0] code);
        logic [CharW-1:0] ch;
        case (code)
            8'h01: ch = 7'h1B; 8'h02: ch = 7'h31; 8'h03: ch = 7'h32; 8'h04: ch = 7'h33;
            8'h05: ch = 7'h34; 8'h06: ch = 7'h35; 8'h07: ch = 7'h36; 8'h08: ch = 7'h37;
            8'h09: ch = 7'h38; 8'h0A: ch = 7'h39; 8'h0B: ch = 7'h30; 8'h0C: ch = 7'h2D;
            8'h0D: ch = 7'h3D; 8'h0E: ch = 7'h08; 8'h0F: ch = 7'h09;
            8'h10: ch = 7'h71; 8'h11: ch = 7'h77; 8'h12: ch = 7'h65; 8'h13: ch = 7'h72;
            8'h14: ch = 7'h74; 8'h15: ch = 7'h79; 8'h16: ch = 7'h75; 8'h17: ch = 7'h69;
            8'h18: ch = 7'h6F; 8'h19: ch = 7'h70; 8'h1A: ch = 7'h5B; 8'h1B: ch = 7'h5D;
            8'h1C: ch = 7'h0A; 8'h1E: ch = 7'h61; 8'h1F: ch = 7'h73;
            8'h20: ch = 7'h64; 8'h21: ch = 7'h66; 8'h22: ch = 7'h67; 8'h23: ch = 7'h68;
            8'h24: ch = 7'h6A; 8'h25: ch = 7'h6B; 8'h26: ch = 7'h6C; 8'h27: ch = 7'h3B;
            8'h28: ch = 7'h27; 8'h29: ch = 7'h60; 8'h2B: ch = 7'h5C; 8'h2C: ch = 7'h7A;
            8'h2D: ch = 7'h78; 8'h2E: ch = 7'h63; 8'h2F: ch = 7'h76;
            8'h30: ch = 7'h62; 8'h31: ch = 7'h6E; 8'h32: ch = 7'h6D; 8'h33: ch = 7'h2C;
            8'h34: ch = 7'h2E; 8'h35: ch = 7'h2F; 8'h37: ch = 7'h2A; 8'h39: ch = 7'h20;
            8'h4A: ch = 7'h2D; 8'h4E: ch = 7'h2B;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // Upper-case table, used without ctrl when shift and caps lock differ.
    function automatic logic [CharW-1:0] f_tab_upper(input logic [CodeW-1:0] code);
        logic [CharW-1:0] ch;
        case (code)
            8'h01: ch = 7'h1B; 8'h02: ch = 7'h21; 8'h03: ch = 7'h40; 8'h04: ch = 7'h23;
            8'h05: ch = 7'h24; 8'h06: ch = 7'h25; 8'h07: ch = 7'h5E; 8'h08: ch = 7'h26;
            8'h09: ch = 7'h2A; 8'h0A: ch = 7'h28; 8'h0B: ch = 7'h29; 8'h0C: ch = 7'h5F;
            8'h0D: ch = 7'h2B; 8'h0E: ch = 7'h08; 8'h0F: ch = 7'h09;
            8'h10: ch = 7'h51; 8'h11: ch = 7'h57; 8'h12: ch = 7'h45; 8'h13: ch = 7'h52;
            8'h14: ch = 7'h54; 8'h15: ch = 7'h59; 8'h16: ch = 7'h55; 8'h17: ch = 7'h49;
            8'h18: ch = 7'h4F; 8'h19: ch = 7'h50; 8'h1A: ch = 7'h7B; 8'h1B: ch = 7'h7D;
            8'h1C: ch = 7'h0A; 8'h1E: ch = 7'h41; 8'h1F: ch = 7'h53;
            8'h20: ch = 7'h44; 8'h21: ch = 7'h46; 8'h22: ch = 7'h47; 8'h23: ch = 7'h48;
            8'h24: ch = 7'h4A; 8'h25: ch = 7'h4B; 8'h26: ch = 7'h4C; 8'h27: ch = 7'h3A;
            8'h28: ch = 7'h22; 8'h29: ch = 7'h7E; 8'h2B: ch = 7'h7C; 8'h2C: ch = 7'h5A;
            8'h2D: ch = 7'h58; 8'h2E: ch = 7'h43; 8'h2F: ch = 7'h56;
            8'h30: ch = 7'h42; 8'h31: ch = 7'h4E; 8'h32: ch = 7'h4D; 8'h33: ch = 7'h3C;
            8'h34: ch = 7'h3E; 8'h35: ch = 7'h3F; 8'h39: ch = 7'h20;
            8'h47: ch = 7'h37; 8'h48: ch = 7'h38; 8'h49: ch = 7'h39; 8'h4A: ch = 7'h2D;
            8'h4B: ch = 7'h34; 8'h4C: ch = 7'h35; 8'h4D: ch = 7'h36; 8'h4E: ch = 7'h2B;
            8'h4F: ch = 7'h31; 8'h50: ch = 7'h32; 8'h51: ch = 7'h33; 8'h52: ch = 7'h30;
            8'h53: ch = 7'h2E;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // Control-character table, used whenever ctrl is held.
    function automatic logic [CharW-1:0] f_tab_ctrl(input logic [CodeW-1:0] code);
        logic [CharW-1:0] ch;
        case (code)
            8'h01: ch = 7'h1B; 8'h07: ch = 7'h1E; 8'h0C: ch = 7'h1F; 8'h0E: ch = 7'h7F;
            8'h10: ch = 7'h11; 8'h11: ch = 7'h17; 8'h12: ch = 7'h05; 8'h13: ch = 7'h12;
            8'h14: ch = 7'h14; 8'h15: ch = 7'h19; 8'h16: ch = 7'h15; 8'h17: ch = 7'h09;
            8'h18: ch = 7'h0F; 8'h19: ch = 7'h10; 8'h1A: ch = 7'h1B; 8'h1B: ch = 7'h1D;
            8'h1C: ch = 7'h0A; 8'h1E: ch = 7'h01; 8'h1F: ch = 7'h13;
            8'h20: ch = 7'h04; 8'h21: ch = 7'h06; 8'h22: ch = 7'h07; 8'h23: ch = 7'h08;
            8'h24: ch = 7'h0A; 8'h25: ch = 7'h0B; 8'h26: ch = 7'h0C; 8'h2B: ch = 7'h1C;
            8'h2C: ch = 7'h1A; 8'h2D: ch = 7'h18; 8'h2E: ch = 7'h03; 8'h2F: ch = 7'h16;
            8'h30: ch = 7'h02; 8'h31: ch = 7'h0E; 8'h32: ch = 7'h0D; 8'h37: ch = 7'h10;
            8'h39: ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> design/sc2a_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc2a_lookup: character table selection
// Picks the ctrl, upper or lower table from the modifier flags and looks up
// the held scancode. A zero character means the code produces no output.
// ----------------------------------------------------------------------------
module sc2a_lookup
    import sc2a_pkg::*;
(
    input  wire logic [CodeW-1:0] i_code,
    input  wire t_mod_flags       i_flags,
    output logic      [CharW-1:0] o_char
);

    // Ctrl has priority; otherwise shift XOR caps lock selects upper case.
    always_comb begin
        if (i_flags.ctrl_held) begin
            o_char = f_tab_ctrl(i_code);
        end else if (i_flags.shift_held ^ i_flags.caps_lock_on) begin
            o_char = f_tab_upper(i_code);
        end else begin
            o_char = f_tab_lower(i_code);
        end
    end

endmodule
`default_nettype wire

>>> design/sc2a_mod_flags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc2a_mod_flags: modifier key state
// Holds shift, ctrl and caps lock. A processed scancode that yields no
// character updates the flags when it is one of the modifier codes.
// ----------------------------------------------------------------------------
module sc2a_mod_flags
    import sc2a_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_update,
    input  wire logic [CodeW-1:0] i_code,
    output t_mod_flags            o_flags
);

    t_mod_flags r_flags;
    t_mod_flags n_flags;

    // Next flag values for a code that produced no character.
    always_comb begin
        n_flags = r_flags;
        case (i_code) inside
            CodeShiftLMake, CodeShiftRMake:   n_flags.shift_held = 1'b1;
            CodeShiftLBreak, CodeShiftRBreak: n_flags.shift_held = 1'b0;
            CodeCtrlMake:                     n_flags.ctrl_held = 1'b1;
            CodeCtrlBreak:                    n_flags.ctrl_held = 1'b0;
            CodeCapsMake:                     n_flags.caps_lock_on = ~r_flags.caps_lock_on;
            default:                          n_flags = r_flags;
        endcase
    end

    // Flag register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_update) begin
            r_flags <= n_flags;
        end
    end

    assign o_flags = r_flags;

endmodule
`default_nettype wire

>>> design/scancode_to_ascii_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_top: set-1 scancode to ASCII decoder
// Registers each scancode, translates it through the modifier-selected table
// and registers the resulting character with its end-of-file flag.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload                           Transfer
//   s_axis    in         tdata[7:0] scancode               i_s_tvalid & o_s_tready
//   m_axis    out        tdata[6:0] character, tuser eof   o_m_tvalid & i_m_tready
//   cfg       in         data[7:0] eof_char                i_cfg_valid (ready tied high)
//
// One scancode is taken per cycle while the output does not stall. A scancode
// then moves to the output register: the table lookup runs while it sits in the
// input register. Codes that give no character only update the modifier flags.
// A stalled output holds the lookup stage, and the input then stalls in turn.
// Synchronous reset clears the flags, both valid bits and sets eof_char to 4.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder_top
    import sc2a_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Scancode stream: tdata = scancode[7:0]
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [CodeW-1:0] i_s_tdata,
    // Character stream: tdata = character[6:0], zero[7]; tuser = is_eof[0]
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [7:0]            o_m_tdata,
    output logic                  o_m_tuser,
    // Configuration: data = eof_char[7:0]
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [7:0]       i_cfg_data
);

    logic             r_in_valid;
    logic [CodeW-1:0] r_in_code;
    logic             r_out_valid;
    logic [CharW-1:0] r_out_char;
    logic             r_out_eof;
    logic [7:0]       r_eof_char;

    t_mod_flags       w_flags;
    logic [CharW-1:0] w_char;
    logic             w_has_char;
    logic             w_fire;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof_char <= EofReset;
        end else if (i_cfg_valid) begin
            r_eof_char <= i_cfg_data;
        end
    end

    // The held scancode is processed when it needs no output slot or one is free.
    assign w_has_char = (w_char != '0);
    assign w_fire     = r_in_valid && (!w_has_char || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_code <= i_s_tdata;
        end
    end

    sc2a_mod_flags u_flags (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_fire && !w_has_char),
        .i_code   (r_in_code),
        .o_flags  (w_flags)
    );

    sc2a_lookup u_lookup (
        .i_code  (r_in_code),
        .i_flags (w_flags),
        .o_char  (w_char)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_has_char) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has_char) begin
            r_out_char <= w_char;
            r_out_eof  <= ({1'b0, w_char} == r_eof_char);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_char};
    assign o_m_tuser  = r_out_eof;

endmodule
`default_nettype wire

>>> design/sc2a_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc2a_checker: port-level checks for the scancode decoder
// Watches the top-level ports for reset behavior, output stability and
// character legality, and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module sc2a_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tuser
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Reset leaves the input side ready for a transfer.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    // A stalled character and its flag hold.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled output changed");

    // Every emitted character is a nonzero seven-bit code.
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6:0] != 7'd0) && !o_m_tdata[7])
        else $error("illegal character emitted");

endmodule

bind scancode_to_ascii_decoder_top sc2a_checker u_sc2a_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

>>> tb/scancode_to_ascii_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_top_tb: self-checking bench for the scancode decoder
// A short table of directed scancodes covers reset behavior, the table edges,
// every modifier key and the end-of-file flag. Random phases follow, each
// after its own write of eof_char. Every scancode is run through a local
// model of the three key maps and the modifier flags, and each character on
// the output stream is checked against the oldest predicted one.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder_top_tb;
    import sc2a_pkg::*;

    localparam logic [7:0] MapLen      = 8'h54;
    localparam int         RandomItems = 800;
    localparam int         NumPhases   = 8;
    localparam int         DrainCycles = 8;
    localparam int         NumDirected = 25;

    // How a directed row is checked
    typedef enum logic [1:0] {
        RowNoChar,
        RowChar,
        RowPredict
    } t_row_check;

    typedef struct packed {
        logic [7:0] code;
        t_row_check check;
        logic [6:0] character;
        logic       is_eof;
    } t_key_row;

    typedef struct packed {
        logic [6:0] character;
        logic       is_eof;
    } t_char_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = 8'h00;
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;
    logic       o_m_tuser;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data  = 8'h00;

    // Local copy of the modifier flags and the end-of-file setting
    logic       shift_down  = 1'b0;
    logic       ctrl_down   = 1'b0;
    logic       caps_on     = 1'b0;
    logic [7:0] eof_setting = EofReset;

    t_char_result pending_chars[$];

    int fail_count    = 0;
    int codes_sent    = 0;
    int chars_checked = 0;
    int eof_hits      = 0;
    int eof_settings  = 1;

    // Key maps, indexed by scancode below 0x54
    logic [7:0] lower_map [0:83] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    logic [7:0] upper_map [0:83] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    logic [7:0] ctrl_map [0:83] = '{
        8'h00, 8'h1B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1E,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h00, 8'h7F, 8'h00,
        8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09,
        8'h0F, 8'h10, 8'h1B, 8'h1D, 8'h0A, 8'h00, 8'h01, 8'h13,
        8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16,
        8'h02, 8'h0E, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    logic [7:0] modifier_codes [0:6] = '{
        CodeShiftLMake, CodeShiftRMake, CodeShiftLBreak, CodeShiftRBreak,
        CodeCtrlMake, CodeCtrlBreak, CodeCapsMake
    };

    // Directed scancodes; the modifier flags carry over from row to row.
    t_key_row directed_keys [0:NumDirected-1] = '{
        '{8'h00, RowNoChar,  7'h00, 1'b0},  // code zero has no character
        '{8'h1E, RowChar,    7'h61, 1'b0},  // plain 'a' after reset
        '{8'h01, RowChar,    7'h1B, 1'b0},  // escape
        '{8'h53, RowNoChar,  7'h00, 1'b0},  // last map entry, empty in lower
        '{8'h54, RowNoChar,  7'h00, 1'b0},  // first code past the maps
        '{8'h7F, RowNoChar,  7'h00, 1'b0},
        '{8'hFF, RowNoChar,  7'h00, 1'b0},
        '{8'h80, RowNoChar,  7'h00, 1'b0},  // break of a plain key
        '{CodeShiftLMake,  RowNoChar,  7'h00, 1'b0},
        '{8'h1E, RowPredict, 7'h00, 1'b0},
        '{8'h53, RowPredict, 7'h00, 1'b0},
        '{CodeCapsMake,    RowNoChar,  7'h00, 1'b0},
        '{8'h1E, RowPredict, 7'h00, 1'b0},  // shift and caps cancel
        '{CodeShiftLBreak, RowNoChar,  7'h00, 1'b0},
        '{8'h10, RowPredict, 7'h00, 1'b0},
        '{CodeCtrlMake,    RowNoChar,  7'h00, 1'b0},
        '{8'h20, RowChar,    7'h04, 1'b1},  // ctrl-D hits the reset eof_char
        '{8'h0E, RowChar,    7'h7F, 1'b0},  // highest character code
        '{CodeShiftRMake,  RowNoChar,  7'h00, 1'b0},
        '{CodeCtrlBreak,   RowNoChar,  7'h00, 1'b0},  // shift stays held
        '{8'h1E, RowPredict, 7'h00, 1'b0},
        '{CodeShiftRBreak, RowNoChar,  7'h00, 1'b0},
        '{8'h1E, RowPredict, 7'h00, 1'b0},
        '{CodeCapsMake,    RowNoChar,  7'h00, 1'b0},
        '{8'h37, RowPredict, 7'h00, 1'b0}
    };

    scancode_to_ascii_decoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Translates one scancode and updates the modifier flags.
    // Returns 1 when the scancode yields a character.
    function automatic bit translate_scancode(input logic [7:0] code,
                                              output logic [6:0] character,
                                              output logic is_eof);
        logic [7:0] raw;
        raw = 8'h00;
        if (code < MapLen) begin
            if (ctrl_down) begin
                raw = ctrl_map[code[6:0]];
            end else if (shift_down ^ caps_on) begin
                raw = upper_map[code[6:0]];
            end else begin
                raw = lower_map[code[6:0]];
            end
        end
        character = raw[6:0];
        is_eof = (raw == eof_setting);
        if (raw != 8'h00) begin
            return 1'b1;
        end
        case (code)
            CodeShiftLMake, CodeShiftRMake:   shift_down = 1'b1;
            CodeShiftLBreak, CodeShiftRBreak: shift_down = 1'b0;
            CodeCtrlMake:                     ctrl_down = 1'b1;
            CodeCtrlBreak:                    ctrl_down = 1'b0;
            CodeCapsMake:                     caps_on = ~caps_on;
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Offers one scancode and returns at the edge of its transfer.
    task automatic offer_scancode(input logic [7:0] code);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= code;
        do begin
            @(negedge i_clk);
        end while (!o_s_tready);
        @(posedge i_clk);
        codes_sent++;
    endtask

    // Drops valid for a number of cycles, with junk on the data lines.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted character has arrived, then lets the
    // pipeline empty of scancodes that give no character.
    task automatic wait_for_chars();
        i_s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_eof_char(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
        end while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        eof_setting = value;
        eof_settings++;
    endtask

    // Random scancode, mostly keys within the maps and modifier traffic
    function automatic logic [7:0] random_scancode();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            return 8'($urandom_range(0, MapLen - 1));
        end else if (sel < 72) begin
            return modifier_codes[3'($urandom_range(0, 6))];
        end else if (sel < 82) begin
            return 8'($urandom_range(0, MapLen - 1)) | 8'h80;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver readiness: changes its stall pattern at random intervals.
    logic [1:0] stall_mode = 2'd0;
    logic [5:0] stall_left = 6'd0;
    always @(posedge i_clk) begin
        if (stall_left == 6'd0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= 6'($urandom_range(8, 60));
        end else begin
            stall_left <= stall_left - 6'd1;
        end
        case (stall_mode)
            2'd0:    i_m_tready <= 1'b1;
            2'd1:    i_m_tready <= 1'($urandom_range(0, 1));
            2'd2:    i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= (stall_left[3:2] == 2'b00);
        endcase
    end

    // Character checker: a transfer completes at the edge after this sample.
    always @(negedge i_clk) begin
        t_char_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_chars.size() == 0) begin
                $error("character %h arrived with none predicted", o_m_tdata);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (o_m_tdata[6:0] !== want.character) begin
                    $error("character: expected %h, got %h", want.character, o_m_tdata[6:0]);
                    fail_count++;
                end
                if (o_m_tuser !== want.is_eof) begin
                    $error("is_eof: expected %b, got %b", want.is_eof, o_m_tuser);
                    fail_count++;
                end
                if (o_m_tdata[7] !== 1'b0) begin
                    $error("tdata pad: expected 0, got %b", o_m_tdata[7]);
                    fail_count++;
                end
                if (want.is_eof) begin
                    eof_hits++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [7:0]   code;
        logic [6:0]   character;
        logic         is_eof;
        bit           has_char;
        int           burst_left;
        logic [7:0]   eof_value;
        logic [7:0]   eof_plan [0:5];

        eof_plan = '{8'h00, 8'hFF, 8'h7F, 8'h0A, 8'h61, 8'h80};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset eof_char
        for (int row = 0; row < NumDirected; row++) begin
            if ($urandom_range(0, 3) == 0) begin
                idle_sender($urandom_range(1, 4));
            end
            offer_scancode(directed_keys[row].code);
            has_char = translate_scancode(directed_keys[row].code, character, is_eof);
            case (directed_keys[row].check)
                RowChar:    pending_chars.push_back({directed_keys[row].character,
                                                     directed_keys[row].is_eof});
                RowPredict: if (has_char) pending_chars.push_back({character, is_eof});
                default: ;
            endcase
        end

        // Random phases, one eof_char setting each
        for (int phase = 0; phase < NumPhases; phase++) begin
            wait_for_chars();
            eof_value = (phase < 6) ? eof_plan[phase] : 8'($urandom_range(1, 127));
            write_eof_char(eof_value);
            burst_left = 0;
            for (int n = 0; n < RandomItems / NumPhases; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0) begin
                        idle_sender($urandom_range(1, 8));
                    end
                end
                code = random_scancode();
                offer_scancode(code);
                if (translate_scancode(code, character, is_eof)) begin
                    pending_chars.push_back({character, is_eof});
                end
                burst_left--;
            end
        end

        wait_for_chars();
        $display("Sent %0d scancodes, checked %0d characters, %0d flagged end of file,",
                 codes_sent, chars_checked, eof_hits);
        $display("across %0d eof_char settings including both extremes.", eof_settings);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $error("timeout with %0d characters outstanding", pending_chars.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> scancode_to_ascii_decoder_top.f
design/sc2a_pkg.sv
design/sc2a_lookup.sv
design/sc2a_mod_flags.sv
design/scancode_to_ascii_decoder_top.sv
design/sc2a_checker.sv
tb/scancode_to_ascii_decoder_top_tb.sv
